/* rtl/multichannel_biquad_cascade_assert.svh */
// Assertion macros for the checker file of the biquad cascade.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef MULTICHANNEL_BIQUAD_CASCADE_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_CASCADE_ASSERT_SVH

// Checked only outside reset.
`define MBQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MBQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mbq_pkg.sv */
// Shared types, codes and field widths of the multichannel biquad cascade.
// No dependencies; imported by mbq_mac, the top level and the checker.
`default_nettype none

package mbq_pkg;

    // default sizes
    localparam int DEF_CHANNELS     = 24;
    localparam int DEF_MAX_SECTIONS = 4;

    // field widths
    localparam int CMD_W     = 2;
    localparam int CH_W      = 5;
    localparam int SAMPLE_W  = 24;
    localparam int WIDX_W    = 5;
    localparam int COEF_W    = 32;
    localparam int STATE_W   = 48;
    localparam int CFG_W     = 3;
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 32;
    localparam int ACC_W     = 50;

    localparam logic [CFG_W-1:0] CFG_RESET = 3'd2;
    localparam int COEFS_PER_SEC = 5;
    localparam int STATES_PER_SEC = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COEF   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATE  = 2'd2;

    // coefficient slots within a section
    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A1 = 3'd3;
    localparam logic [2:0] SLOT_A2 = 3'd4;

    // product order within a section
    localparam logic [2:0] STEP_B0X = 3'd0;
    localparam logic [2:0] STEP_B1X = 3'd1;
    localparam logic [2:0] STEP_A1O = 3'd2;
    localparam logic [2:0] STEP_B2X = 3'd3;
    localparam logic [2:0] STEP_A2O = 3'd4;

    typedef struct packed {
        logic mul_lo;
        logic mul_hi;
        logic rnd;
        logic acc_add;
        logic acc_sub;
        logic acc_load;
    } mbq_mac_ctl_t;

    function automatic logic [2:0] coef_slot(input logic [2:0] step);
        logic [2:0] slot;
        case (step)
            STEP_B0X: slot = SLOT_B0;
            STEP_B1X: slot = SLOT_B1;
            STEP_A1O: slot = SLOT_A1;
            STEP_B2X: slot = SLOT_B2;
            STEP_A2O: slot = SLOT_A2;
            default:  slot = SLOT_B0;
        endcase
        return slot;
    endfunction

endpackage

`default_nettype wire

/* rtl/mbq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mbq_ram #(
    parameter  int WIDTH = 48,
    parameter  int DEPTH = 192,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/mbq_mac.sv */
// Shared multiply, round, saturate and accumulate unit of the cascade.
// Depends on mbq_pkg; each step is commanded by the sequencer in the top level.
`default_nettype none

module mbq_mac (
    input  wire logic                                clk,
    input  wire mbq_pkg::mbq_mac_ctl_t               ctl,
    input  wire logic signed [mbq_pkg::COEF_W-1:0]   coef,
    input  wire logic signed [mbq_pkg::STATE_W-1:0]  operand,
    input  wire logic signed [mbq_pkg::STATE_W-1:0]  addend,
    output logic                                     rnd_ovf,
    output logic signed [mbq_pkg::STATE_W-1:0]       sat_val,
    output logic                                     sat_ovf
);

    import mbq_pkg::*;

    localparam logic [STATE_W-1:0] MAX48 = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic [STATE_W-1:0] MIN48 = {1'b1, {(STATE_W-1){1'b0}}};
    localparam logic [57:0]        HALF  = 58'd134217728;  // 2^27

    logic signed [24:0]        mul_b;
    logic signed [56:0]        prod;
    logic signed [56:0]        p_reg;
    logic        [57:0]        lo_reg;
    logic        [79:0]        t_sum;
    logic        [51:0]        q;
    logic        [STATE_W-1:0] m_sat;
    logic signed [STATE_W-1:0] m_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   m_ext;

    // 32 x 25 partial products: low 24 bits unsigned, high 24 bits signed
    assign mul_b = ctl.mul_hi ? {operand[STATE_W-1], operand[STATE_W-1:24]}
                              : {1'b0, operand[23:0]};
    assign prod  = coef * mul_b;

    // hi * 2^24 + lo + 2^27, floor by 2^28
    assign t_sum = {p_reg[55:0], 24'b0} + {{22{lo_reg[57]}}, lo_reg};
    assign q     = t_sum[79:28];
    assign rnd_ovf = !((&q[51:47]) || !(|q[51:47]));
    assign m_sat = rnd_ovf ? (q[51] ? MIN48 : MAX48) : q[STATE_W-1:0];

    assign m_ext   = {{2{m_reg[STATE_W-1]}}, m_reg};
    assign sat_ovf = !((&acc_reg[49:47]) || !(|acc_reg[49:47]));
    assign sat_val = sat_ovf ? (acc_reg[ACC_W-1] ? MIN48 : MAX48)
                             : acc_reg[STATE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.mul_lo)
        begin
            p_reg <= prod;
        end
        if (ctl.mul_hi)
        begin
            lo_reg <= {p_reg[56], p_reg} + HALF;
            p_reg  <= prod;
        end
        if (ctl.rnd)
        begin
            m_reg <= m_sat;
        end
        if (ctl.acc_load)
        begin
            acc_reg <= {{2{addend[STATE_W-1]}}, addend};
        end
        else if (ctl.acc_add)
        begin
            acc_reg <= acc_reg + m_ext;
        end
        else if (ctl.acc_sub)
        begin
            acc_reg <= acc_reg - m_ext;
        end
    end

endmodule

`default_nettype wire

/* rtl/multichannel_biquad_cascade.sv */
// Top level of the multichannel biquad cascade: sequencer, command decode,
// coefficient and state RAMs. Depends on mbq_pkg, mbq_ram and mbq_mac.
//
// Usage
//  - s_axis: one command per transfer. tuser carries the command (filter,
//    load coefficient word, load state word); tdata carries channel, sample,
//    word index, coefficient word and state word.
//  - m_axis: one result per filter command: channel, saturated Q1.23 sample
//    and overflow flag. Loads and commands that are ignored return nothing.
//  - cfg: sections_in_use, taken on any cycle with cfg_valid (cfg_ready is
//    always high); write it only while the block is idle.
//  - Throughput: loads are taken back to back; a filter command keeps
//    s_axis_tready low until its result is in the output register. Each of
//    the n sections, n being sections_in_use capped at MAX_SECTIONS, is five
//    32x48 products on the single 32x25 multiplier (low and high partial
//    product, round, accumulate), two state reads and three saturate/store steps.
//  - Output: m_axis_tvalid rises when the FIN step loads the output register.
//  - Reset: clears sections_in_use to 2 and then sweeps both RAMs to zero
//    over max(2*CHANNELS*MAX_SECTIONS, 5*MAX_SECTIONS) addresses (192 by default),
//    with s_axis_tready low. cfg writes are taken during the sweep.
//  - Stall: a finished result waits in the output register; the block keeps
//    taking loads and may start the next filter, which then holds in its last
//    step until the previous result is taken.
`default_nettype none

module multichannel_biquad_cascade #(
    parameter int CHANNELS     = mbq_pkg::DEF_CHANNELS,
    parameter int MAX_SECTIONS = mbq_pkg::DEF_MAX_SECTIONS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // tdata: channel[4:0], sample[28:5], word_index[33:29],
    //        coeff_value[65:34], state_value[113:66], zero[119:114]
    input  wire logic [mbq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: command[1:0]
    input  wire logic [mbq_pkg::CMD_W-1:0]       s_axis_tuser,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: channel_res[4:0], filtered_sample[28:5], overflow[29], zero[31:30]
    output logic [mbq_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [mbq_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready
);

    import mbq_pkg::*;

    localparam int SW_DEPTH  = CHANNELS * MAX_SECTIONS * STATES_PER_SEC;
    localparam int CF_DEPTH  = MAX_SECTIONS * COEFS_PER_SEC;
    localparam int SW_AW     = (SW_DEPTH > 1) ? $clog2(SW_DEPTH) : 1;
    localparam int CF_AW     = $clog2(CF_DEPTH);
    localparam int CLR_DEPTH = (SW_DEPTH > CF_DEPTH) ? SW_DEPTH : CF_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int SEC_W     = $clog2(MAX_SECTIONS + 1);

    // sequencer states
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RDZ   = 4'd2;  // read z0, b0
    localparam logic [3:0] ST_LDZ   = 4'd3;  // acc <= z0, read z1
    localparam logic [3:0] ST_ML    = 4'd4;  // low partial product
    localparam logic [3:0] ST_MH    = 4'd5;  // high partial product
    localparam logic [3:0] ST_RND   = 4'd6;  // round and saturate product
    localparam logic [3:0] ST_ACC   = 4'd7;  // add or subtract into acc
    localparam logic [3:0] ST_SAT   = 4'd8;  // saturate acc, store
    localparam logic [3:0] ST_FIN   = 4'd9;  // final rounding to Q1.23

    // input fields
    logic [CMD_W-1:0]           in_cmd;
    logic [CH_W-1:0]            in_ch;
    logic [SAMPLE_W-1:0]        in_sample;
    logic [WIDX_W-1:0]          in_widx;
    logic [COEF_W-1:0]          in_coef;
    logic [STATE_W-1:0]         in_state;

    assign in_cmd    = s_axis_tuser;
    assign in_ch     = s_axis_tdata[4:0];
    assign in_sample = s_axis_tdata[28:5];
    assign in_widx   = s_axis_tdata[33:29];
    assign in_coef   = s_axis_tdata[65:34];
    assign in_state  = s_axis_tdata[113:66];

    // control registers
    logic [3:0]      state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [2:0]      step_reg, step_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic            ov_reg, ov_next;
    logic [CFG_W-1:0] sections_reg;
    logic            out_valid_reg, out_valid_next;

    // payload registers
    logic [CH_W-1:0]            ch_reg;
    logic signed [STATE_W-1:0]  x_reg;
    logic signed [STATE_W-1:0]  o_reg;
    logic [CH_W-1:0]            out_ch_reg;
    logic [SAMPLE_W-1:0]        out_y_reg;
    logic                       out_ov_reg;

    logic           in_xfer;
    logic           ch_ok;
    logic           start_filter;
    logic           out_load;
    logic [3:0]     n_eff;
    logic           last_sec;
    logic           clearing;

    // RAM ports
    logic                 st_we, st_re;
    logic [SW_AW-1:0]     st_waddr, st_raddr, st_a0, st_a1;
    logic [STATE_W-1:0]   st_wdata, st_rdata;
    logic                 cf_we, cf_re;
    logic [CF_AW-1:0]     cf_waddr, cf_raddr;
    logic [COEF_W-1:0]    cf_wdata, cf_rdata;
    logic [2:0]           cf_slot;

    // shared unit
    mbq_mac_ctl_t               mac_ctl;
    logic signed [STATE_W-1:0]  mac_operand;
    logic signed [STATE_W-1:0]  mac_addend;
    logic                       rnd_ovf;
    logic signed [STATE_W-1:0]  sat_val;
    logic                       sat_ovf;

    // final rounding
    logic [48:0]    y_round;
    logic [39:0]    y_q;
    logic           y_ovf;
    logic [SAMPLE_W-1:0] y_sat;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign ch_ok         = 32'(in_ch) < CHANNELS;
    assign start_filter  = in_xfer && ch_ok && (in_cmd == CMD_FILTER);
    assign clearing      = (state_reg == ST_CLEAR);

    assign n_eff    = ({1'b0, sections_reg} > 4'(MAX_SECTIONS)) ? 4'(MAX_SECTIONS)
                                                               : {1'b0, sections_reg};
    assign last_sec = (4'(sec_reg) + 4'd1) >= n_eff;

    // state words of the current channel and section
    assign st_a0 = SW_AW'((32'(ch_reg) * MAX_SECTIONS + 32'(sec_reg)) * STATES_PER_SEC);
    assign st_a1 = SW_AW'((32'(ch_reg) * MAX_SECTIONS + 32'(sec_reg)) * STATES_PER_SEC + 1);

    // ---------------- RAM port steering ----------------
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = st_a0;
        st_wdata = sat_val;
        cf_we    = 1'b0;
        cf_waddr = CF_AW'(in_widx);
        cf_wdata = in_coef;
        if (clearing)
        begin
            st_we    = 32'(clr_cnt_reg) < SW_DEPTH;
            st_waddr = SW_AW'(clr_cnt_reg);
            st_wdata = '0;
            cf_we    = 32'(clr_cnt_reg) < CF_DEPTH;
            cf_waddr = CF_AW'(clr_cnt_reg);
            cf_wdata = '0;
        end
        else if (in_xfer && ch_ok)
        begin
            if (in_cmd == CMD_COEF)
            begin
                cf_we = 32'(in_widx) < CF_DEPTH;
            end
            if (in_cmd == CMD_STATE)
            begin
                st_we    = 32'(in_widx) < MAX_SECTIONS * STATES_PER_SEC;
                st_waddr = SW_AW'(32'(in_ch) * MAX_SECTIONS * STATES_PER_SEC
                                  + 32'(in_widx));
                st_wdata = in_state;
            end
        end
        else if (state_reg == ST_SAT)
        begin
            // new z0 after the a1 product, new z1 after the a2 product
            if (step_reg == STEP_A1O)
            begin
                st_we    = 1'b1;
                st_waddr = st_a0;
            end
            else if (step_reg == STEP_A2O)
            begin
                st_we    = 1'b1;
                st_waddr = st_a1;
            end
        end
    end

    // reads: state words in RDZ/LDZ, next coefficient one step ahead
    assign st_re    = (state_reg == ST_RDZ) || (state_reg == ST_LDZ);
    assign st_raddr = (state_reg == ST_LDZ) ? st_a1 : st_a0;
    assign cf_re    = (state_reg == ST_RDZ) ||
                      ((state_reg == ST_RND) && (step_reg != STEP_A2O));
    assign cf_slot  = (state_reg == ST_RDZ) ? SLOT_B0 : coef_slot(step_reg + 3'd1);
    assign cf_raddr = CF_AW'(32'(sec_reg) * COEFS_PER_SEC + 32'(cf_slot));

    mbq_ram #(
        .WIDTH (STATE_W),
        .DEPTH (SW_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    mbq_ram #(
        .WIDTH (COEF_W),
        .DEPTH (CF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (cf_we),
        .waddr (cf_waddr),
        .wdata (cf_wdata),
        .re    (cf_re),
        .raddr (cf_raddr),
        .rdata (cf_rdata)
    );

    // ---------------- shared unit control ----------------
    always_comb
    begin
        mac_ctl    = '0;
        mac_addend = $signed(st_rdata);
        case (state_reg)
            ST_LDZ:  mac_ctl.acc_load = 1'b1;                // acc <= z0
            ST_ML:   mac_ctl.mul_lo   = 1'b1;
            ST_MH:   mac_ctl.mul_hi   = 1'b1;
            ST_RND:  mac_ctl.rnd      = 1'b1;
            ST_ACC:
            begin
                if ((step_reg == STEP_A1O) || (step_reg == STEP_A2O))
                begin
                    mac_ctl.acc_sub = 1'b1;
                end
                else
                begin
                    mac_ctl.acc_add = 1'b1;
                end
            end
            ST_SAT:
            begin
                // after o: acc <= z1; after new z0: acc <= 0
                if (step_reg == STEP_B0X)
                begin
                    mac_ctl.acc_load = 1'b1;
                end
                else if (step_reg == STEP_A1O)
                begin
                    mac_ctl.acc_load = 1'b1;
                    mac_addend       = '0;
                end
            end
            default: mac_ctl = '0;
        endcase
    end

    assign mac_operand = ((step_reg == STEP_A1O) || (step_reg == STEP_A2O)) ? o_reg : x_reg;

    mbq_mac u_mac (
        .clk     (clk),
        .ctl     (mac_ctl),
        .coef    ($signed(cf_rdata)),
        .operand (mac_operand),
        .addend  (mac_addend),
        .rnd_ovf (rnd_ovf),
        .sat_val (sat_val),
        .sat_ovf (sat_ovf)
    );

    // ---------------- final rounding to Q1.23 ----------------
    assign y_round = {x_reg[STATE_W-1], x_reg} + 49'd256;
    assign y_q     = y_round[48:9];
    assign y_ovf   = !((&y_q[39:23]) || !(|y_q[39:23]));
    assign y_sat   = y_ovf ? (y_q[39] ? {1'b1, 23'b0} : {1'b0, {23{1'b1}}}) : y_q[23:0];

    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        step_next      = step_reg;
        sec_next       = sec_reg;
        ov_next        = ov_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == CLR_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start_filter)
                begin
                    sec_next   = '0;
                    step_next  = STEP_B0X;
                    ov_next    = 1'b0;
                    state_next = (n_eff == 4'd0) ? ST_FIN : ST_RDZ;
                end
            end
            ST_RDZ:  state_next = ST_LDZ;
            ST_LDZ:  state_next = ST_ML;
            ST_ML:   state_next = ST_MH;
            ST_MH:   state_next = ST_RND;
            ST_RND:
            begin
                ov_next    = ov_reg | rnd_ovf;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if ((step_reg == STEP_B0X) || (step_reg == STEP_A1O) ||
                    (step_reg == STEP_A2O))
                begin
                    state_next = ST_SAT;
                end
                else
                begin
                    step_next  = step_reg + 3'd1;
                    state_next = ST_ML;
                end
            end
            ST_SAT:
            begin
                ov_next = ov_reg | sat_ovf;
                case (step_reg)
                    STEP_B0X:
                    begin
                        step_next  = STEP_B1X;
                        state_next = ST_ML;
                    end
                    STEP_A1O:
                    begin
                        step_next  = STEP_B2X;
                        state_next = ST_ML;
                    end
                    STEP_A2O:
                    begin
                        step_next  = STEP_B0X;
                        sec_next   = sec_reg + 1'b1;
                        state_next = last_sec ? ST_FIN : ST_RDZ;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            step_reg      <= STEP_B0X;
            sec_reg       <= '0;
            ov_reg        <= 1'b0;
            sections_reg  <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            step_reg      <= step_next;
            sec_reg       <= sec_next;
            ov_reg        <= ov_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                sections_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start_filter)
        begin
            ch_reg <= in_ch;
            x_reg  <= {{(STATE_W-SAMPLE_W-9){in_sample[SAMPLE_W-1]}}, in_sample, 9'b0};
        end
        else if (state_reg == ST_SAT)
        begin
            if (step_reg == STEP_B0X)
            begin
                o_reg <= sat_val;
            end
            else if (step_reg == STEP_A2O)
            begin
                x_reg <= o_reg;   // section output feeds the next section
            end
        end
        if (out_load)
        begin
            out_ch_reg <= ch_reg;
            out_y_reg  <= y_sat;
            out_ov_reg <= ov_reg | y_ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_ov_reg, out_y_reg, out_ch_reg};

endmodule

`default_nettype wire

/* rtl/mbq_checker.sv */
// Port-level checker for the multichannel biquad cascade, bound to the top.
// Depends on mbq_pkg and multichannel_biquad_cascade_assert.svh.
`default_nettype none

module mbq_checker #(
    parameter int CHANNELS = mbq_pkg::DEF_CHANNELS
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic [mbq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input wire logic [mbq_pkg::CMD_W-1:0]       s_axis_tuser,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [mbq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready
);

    import mbq_pkg::*;

    `include "multichannel_biquad_cascade_assert.svh"

    // nothing offered or taken in the cycle after reset is seen
    `MBQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_axis_tvalid && !s_axis_tready, "active during reset")

    // a stalled result holds
    `MBQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")

    // a filter transfer for an existing channel makes the block busy
    `MBQ_ASSERT(a_busy_after_filter, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_FILTER) && (32'(s_axis_tdata[4:0]) < CHANNELS) |=> !s_axis_tready, "ready after filter transfer")

    // a new result only comes out of a busy period
    `MBQ_ASSERT(a_result_from_busy, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result without filtering")

endmodule

bind multichannel_biquad_cascade mbq_checker #(.CHANNELS(CHANNELS)) u_mbq_checker (.*);

`default_nettype wire

/* bench/multichannel_biquad_cascade_tb.sv */
// Self-checking bench for multichannel_biquad_cascade: directed and random command transfers,
// a bit-true cascade predictor and an in-order result scoreboard.
// Depends on mbq_pkg and the block's RTL only; reads no files.
`default_nettype none

module multichannel_biquad_cascade_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbq_pkg::*;

    localparam int N_CHAN  = DEF_CHANNELS;
    localparam int N_SECT  = DEF_MAX_SECTIONS;
    localparam int N_COEF  = N_SECT * COEFS_PER_SEC;
    localparam int N_ZSLOT = N_SECT * STATES_PER_SEC;

    // the one command code with no name in the package; the block ignores it
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    // drain wait: the slowest filter, over all MAX_SECTIONS sections, and slack on top
    localparam int DRAIN_CYCLES     = 25 * N_SECT + 10;
    localparam int SINK_HOLD_CYCLES = 400;

    // saturation bounds, held wide so that comparisons never wrap
    localparam logic signed [95:0] ST_MAX  = 96'sh7FFF_FFFF_FFFF;
    localparam logic signed [95:0] ST_MIN  = -ST_MAX - 96'sd1;
    localparam logic signed [95:0] SMP_MAX = 96'sd8388607;
    localparam logic signed [95:0] SMP_MIN = -96'sd8388608;

    typedef struct {
        logic [CMD_W-1:0]           command;
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic [WIDX_W-1:0]          word_index;
        logic signed [COEF_W-1:0]   coeff_value;
        logic signed [STATE_W-1:0]  state_value;
    } bq_cmd_t;

    typedef struct {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       overflow;
    } bq_res_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [CMD_W-1:0]     s_axis_tuser  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;

    // ------------------------------------------------------------------
    // Shadow of the block's state, kept in transfer order
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0]  coef_shadow [N_COEF];
    logic signed [STATE_W-1:0] z_shadow [N_CHAN * N_ZSLOT];
    logic [CFG_W-1:0]          sections_shadow;
    bq_res_t                   pending_results [$];
    int                        err_count = 0;

    // idling controls: sender gaps, receiver stalls, one long receiver hold-off
    bit src_idle_on   = 1'b1;
    bit sink_idle_on  = 1'b1;
    bit sink_hold_req = 1'b0;

    multichannel_biquad_cascade u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cascade predictor
    // ------------------------------------------------------------------
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [95:0] v,
                                                            inout bit ovf);
        if (v > ST_MAX)
        begin
            ovf = 1'b1;
            return ST_MAX[STATE_W-1:0];
        end
        if (v < ST_MIN)
        begin
            ovf = 1'b1;
            return ST_MIN[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

    // Q4.28 x Q16.32, rounded half up to Q16.32, saturated to the state width
    function automatic logic signed [STATE_W-1:0] mul_q28(input logic signed [COEF_W-1:0] c,
                                                          input logic signed [STATE_W-1:0] v,
                                                          inout bit ovf);
        logic signed [95:0] p;
        p = 96'(c) * 96'(v);
        p = (p + 96'sd134217728) >>> 28;
        return sat_state(p, ovf);
    endfunction

    // One sample through the active sections (transposed DF-II, a0 = 1).
    // Updates the channel's state words in the shadow.
    function automatic bq_res_t filter_sample(input bq_cmd_t cmd);
        bq_res_t                   res;
        bit                        ovf;
        int                        nsec;
        int                        sec;
        int                        zb;
        int                        cb;
        logic signed [STATE_W-1:0] x;
        logic signed [STATE_W-1:0] o;
        logic signed [STATE_W-1:0] pa;
        logic signed [STATE_W-1:0] pb;
        logic signed [95:0]        acc;
        ovf  = 1'b0;
        // section counts beyond the store act as a full cascade
        nsec = (sections_shadow > N_SECT) ? N_SECT : int'(sections_shadow);
        x    = STATE_W'(cmd.sample) <<< 9;
        for (sec = 0; sec < nsec; sec++)
        begin
            zb  = (cmd.channel * N_SECT + sec) * STATES_PER_SEC;
            cb  = sec * COEFS_PER_SEC;
            pa  = mul_q28(coef_shadow[cb + SLOT_B0], x, ovf);
            acc = 96'(pa) + 96'(z_shadow[zb]);
            o   = sat_state(acc, ovf);
            pa  = mul_q28(coef_shadow[cb + SLOT_B1], x, ovf);
            pb  = mul_q28(coef_shadow[cb + SLOT_A1], o, ovf);
            acc = 96'(pa) - 96'(pb) + 96'(z_shadow[zb + 1]);
            z_shadow[zb] = sat_state(acc, ovf);
            pa  = mul_q28(coef_shadow[cb + SLOT_B2], x, ovf);
            pb  = mul_q28(coef_shadow[cb + SLOT_A2], o, ovf);
            acc = 96'(pa) - 96'(pb);
            z_shadow[zb + 1] = sat_state(acc, ovf);
            x = o;
        end
        // back to Q1.23, rounded half up, saturated
        acc = (96'(x) + 96'sd256) >>> 9;
        if (acc > SMP_MAX)
        begin
            acc = SMP_MAX;
            ovf = 1'b1;
        end
        else if (acc < SMP_MIN)
        begin
            acc = SMP_MIN;
            ovf = 1'b1;
        end
        res.channel  = cmd.channel;
        res.sample   = acc[SAMPLE_W-1:0];
        res.overflow = ovf;
        return res;
    endfunction

    // Apply one accepted command transfer to the shadow
    function automatic void predict_transfer(input bq_cmd_t cmd);
        if (cmd.channel >= N_CHAN)
            return;
        case (cmd.command)
            CMD_FILTER: pending_results.push_back(filter_sample(cmd));
            CMD_COEF:
                if (cmd.word_index < N_COEF)
                    coef_shadow[cmd.word_index] = cmd.coeff_value;
            CMD_STATE:
                if (cmd.word_index < N_ZSLOT)
                    z_shadow[cmd.channel * N_ZSLOT + cmd.word_index] = cmd.state_value;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic bq_cmd_t make_cmd(input logic [CMD_W-1:0] command,
                                         input int channel,
                                         input logic signed [SAMPLE_W-1:0] sample,
                                         input int word_index,
                                         input logic signed [COEF_W-1:0] coeff_value,
                                         input logic signed [STATE_W-1:0] state_value);
        bq_cmd_t c;
        c.command     = command;
        c.channel     = CH_W'(channel);
        c.sample      = sample;
        c.word_index  = WIDX_W'(word_index);
        c.coeff_value = coeff_value;
        c.state_value = state_value;
        return c;
    endfunction

    // narrow coefficients (-0.5 <= c < 0.5) keep a section stable; wide ones span Q4.28
    function automatic logic signed [COEF_W-1:0] pick_coef(input bit wide);
        if (wide)
            return COEF_W'($urandom);
        return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    endfunction

    function automatic logic signed [STATE_W-1:0] pick_state(input bit wide);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (wide)
            return r[STATE_W-1:0];
        return STATE_W'($signed(r[33:0]));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_MAX[SAMPLE_W-1:0];
            1:       return SMP_MIN[SAMPLE_W-1:0];
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed traffic (filters, loads); the rest is traffic the
    // block must drop. Returns 0 for the dropped kind.
    function automatic bit random_cmd(input bit wide, output bq_cmd_t cmd);
        int roll;
        roll            = $urandom_range(0, 99);
        cmd.command     = CMD_FILTER;
        cmd.channel     = CH_W'($urandom_range(0, N_CHAN - 1));
        cmd.sample      = pick_sample();
        cmd.word_index  = WIDX_W'($urandom);
        cmd.coeff_value = pick_coef(wide || $urandom_range(0, 7) == 0);
        cmd.state_value = pick_state($urandom_range(0, 3) == 0);
        if (roll < 70)
            return 1'b1;
        if (roll < 80)
        begin
            cmd.command    = CMD_COEF;
            cmd.word_index = WIDX_W'($urandom_range(0, N_COEF - 1));
            return 1'b1;
        end
        if (roll < 88)
        begin
            cmd.command    = CMD_STATE;
            cmd.word_index = WIDX_W'($urandom_range(0, N_ZSLOT - 1));
            return 1'b1;
        end
        case ($urandom_range(0, 3))
            0:
            begin
                cmd.command = CMD_NONE;
                cmd.channel = CH_W'($urandom);
            end
            1:
            begin
                cmd.command = CMD_W'($urandom);
                cmd.channel = CH_W'($urandom_range(N_CHAN, 31));
            end
            2:
            begin
                cmd.command    = CMD_COEF;
                cmd.word_index = WIDX_W'($urandom_range(N_COEF, 31));
            end
            default:
            begin
                cmd.command    = CMD_STATE;
                cmd.word_index = WIDX_W'($urandom_range(N_ZSLOT, 31));
            end
        endcase
        return 1'b0;
    endfunction

    // One command transfer on s_axis, with an optional gap before it.
    // tvalid stays high afterwards; the next call or drain() decides.
    task automatic send_cmd(input bq_cmd_t cmd);
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        // zero pad in the top six bits
        s_axis_tdata  <= {6'b0, cmd.state_value, cmd.coeff_value, cmd.word_index,
                          cmd.sample, cmd.channel};
        s_axis_tuser  <= cmd.command;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_transfer(cmd);
    endtask

    task automatic write_sections(input logic [CFG_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sections_shadow = value;
    endtask

    // Stop offering, wait for every expected result, then let a trailing
    // load or dropped command settle before the block is touched again.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Extremes, saturation in products, states and output, dropped commands,
    // zero sections and a section count beyond the store.
    task automatic test_directed();
        // taken while the reset sweep is still running
        write_sections(3'd1);
        // unity b0: straight pass-through over the sample range
        send_cmd(make_cmd(CMD_COEF, 0, '0, SLOT_B0, 32'sh1000_0000, '0));
        send_cmd(make_cmd(CMD_FILTER, 0, 24'sh7F_FFFF, 0, '0, '0));
        send_cmd(make_cmd(CMD_FILTER, 23, 24'sh80_0000, 31, '1, '1));
        send_cmd(make_cmd(CMD_FILTER, 7, 24'sh00_0000, 0, '0, '0));
        send_cmd(make_cmd(CMD_FILTER, 16, 24'sh00_0001, 0, '0, '0));
        // extreme b0: output saturates
        send_cmd(make_cmd(CMD_COEF, 0, '0, SLOT_B0, 32'sh7FFF_FFFF, '0));
        send_cmd(make_cmd(CMD_FILTER, 1, 24'sh7F_FFFF, 0, '0, '0));
        send_cmd(make_cmd(CMD_COEF, 0, '0, SLOT_B0, 32'sh8000_0000, '0));
        send_cmd(make_cmd(CMD_FILTER, 2, 24'sh80_0000, 0, '0, '0));
        // full-scale z0 with a1 at -8: product and state saturate
        send_cmd(make_cmd(CMD_STATE, 5, '0, 0, '0, 48'sh7FFF_FFFF_FFFF));
        send_cmd(make_cmd(CMD_COEF, 0, '0, SLOT_B0, '0, '0));
        send_cmd(make_cmd(CMD_COEF, 0, '0, SLOT_A1, 32'sh8000_0000, '0));
        send_cmd(make_cmd(CMD_FILTER, 5, '0, 0, '0, '0));
        // commands the block must drop without side effects
        send_cmd(make_cmd(CMD_NONE, 0, 24'sh7F_FFFF, 0, 32'sh7FFF_FFFF, '1));
        send_cmd(make_cmd(CMD_FILTER, N_CHAN, 24'sh12_3456, 0, '0, '0));
        send_cmd(make_cmd(CMD_FILTER, 31, 24'sh12_3456, 0, '0, '0));
        send_cmd(make_cmd(CMD_COEF, 0, '0, N_COEF, 32'sh7FFF_FFFF, '0));
        send_cmd(make_cmd(CMD_COEF, 0, '0, 31, 32'sh7FFF_FFFF, '0));
        send_cmd(make_cmd(CMD_STATE, 0, '0, N_ZSLOT, '0, 48'sh7FFF_FFFF_FFFF));
        send_cmd(make_cmd(CMD_STATE, 23, '0, 31, '0, 48'sh8000_0000_0000));
        // would show aliasing of the dropped loads
        send_cmd(make_cmd(CMD_FILTER, 0, 24'sh7F_FFFF, 0, '0, '0));
        drain();
        // no sections: sample through unchanged
        write_sections(3'd0);
        send_cmd(make_cmd(CMD_FILTER, 3, 24'sh5A_5A5A, 0, '0, '0));
        drain();
        // count above the store acts as the full cascade
        write_sections(3'd7);
        send_cmd(make_cmd(CMD_FILTER, 4, 24'sh7F_FFFF, 0, '0, '0));
        drain();
        write_sections(3'd4);
        send_cmd(make_cmd(CMD_FILTER, 23, 24'sh80_0000, 0, '0, '0));
        drain();
    endtask

    // Phases over several section counts, each with a fresh coefficient set
    // and then a mixed stream; every third phase uses wide coefficients.
    task automatic test_random_phases();
        logic [CFG_W-1:0] plan [11] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd2,
                                        3'd5, 3'd1, 3'd3, 3'd7, 3'd6};
        bq_cmd_t          c;
        bit               wide;
        int               sent;
        for (int p = 0; p < 11; p++)
        begin
            drain();
            write_sections(plan[p]);
            wide = (p % 3 == 2);
            for (int k = 0; k < N_COEF; k++)
                send_cmd(make_cmd(CMD_COEF, $urandom_range(0, N_CHAN - 1), SAMPLE_W'($urandom),
                                  k, pick_coef(wide), pick_state(1'b1)));
            sent = 0;
            while (sent < 130)
            begin
                if (random_cmd(wide, c))
                    sent++;
                send_cmd(c);
            end
        end
        drain();
    endtask

    // Receiver holds off for a long stretch while commands keep coming, so
    // the output register and the pending filter fill and s_axis stalls.
    task automatic test_output_hold_off();
        bq_cmd_t c;
        write_sections(3'd1);
        sink_hold_req = 1'b1;
        repeat (40)
        begin
            void'(random_cmd(1'b0, c));
            send_cmd(c);
        end
        drain();
    endtask

    // Back-to-back transfers on both sides, no idling at all
    task automatic test_no_idle_tail();
        bq_cmd_t c;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        write_sections(3'd2);
        repeat (200)
        begin
            void'(random_cmd(1'b0, c));
            send_cmd(c);
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts plus the one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : sink_ready
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                stall_left    = SINK_HOLD_CYCLES;
            end
            else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result check: each m_axis transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        bq_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: channel_res %0d",
                       m_axis_tdata[CH_W-1:0]);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[CH_W-1:0] !== want.channel)
                begin
                    $error("channel_res: expected %0d, actual %0d",
                           want.channel, m_axis_tdata[CH_W-1:0]);
                    err_count++;
                end
                if (m_axis_tdata[CH_W +: SAMPLE_W] !== want.sample)
                begin
                    $error("filtered_sample: expected %0d, actual %0d",
                           want.sample, $signed(m_axis_tdata[CH_W +: SAMPLE_W]));
                    err_count++;
                end
                if (m_axis_tdata[CH_W + SAMPLE_W] !== want.overflow)
                begin
                    $error("overflow: expected %0d, actual %0d",
                           want.overflow, m_axis_tdata[CH_W + SAMPLE_W]);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        sections_shadow = CFG_RESET;
        foreach (coef_shadow[i])
            coef_shadow[i] = '0;
        foreach (z_shadow[i])
            z_shadow[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_phases();
        test_output_hold_off();
        test_no_idle_tail();

        if (err_count == 0)
            $display("PASS multichannel_biquad_cascade");
        else
            $display("FAIL multichannel_biquad_cascade");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("FAIL multichannel_biquad_cascade");
        $finish;
    end

endmodule

`default_nettype wire

/* multichannel_biquad_cascade.f */
+incdir+rtl
rtl/mbq_pkg.sv
rtl/mbq_ram.sv
rtl/mbq_mac.sv
rtl/multichannel_biquad_cascade.sv
rtl/mbq_checker.sv
bench/multichannel_biquad_cascade_tb.sv
